[rtl/core/ordered_selection_set_core_defines.svh]
// Assertion macros shared by the ordered selection set RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ORDERED_SELECTION_SET_CORE_DEFINES_SVH
`define ORDERED_SELECTION_SET_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define OSS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication checked at the same clock edge.
`define OSS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/oss_pkg.sv]
// Types and fixed field widths of the ordered selection set.
// Used by oss_outreg, oss_ctrl and the top level; depends on nothing.
package oss_pkg;

    localparam int ID_W        = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 5;
    localparam int MEMBERS_W   = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ID_W - SLOT_W - MEMBERS_W;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SELECTED    = 3'd0,
        STAT_UNSELECTED  = 3'd1,
        STAT_ALREADY     = 3'd2,
        STAT_NOT_MEMBER  = 3'd3,
        STAT_FULL        = 3'd4,
        STAT_CLEARED     = 3'd5,
        STAT_CLEAR_EMPTY = 3'd6
    } t_status;

    typedef struct packed {
        t_status                status;
        logic [ID_W-1:0]        object_id;
        logic [SLOT_W-1:0]      slot;
        logic [MEMBERS_W-1:0]   members;
        logic                   last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_ADD_TRD,
        ST_ADD_TWR,
        ST_DEL,
        ST_DEL_PRD,
        ST_DEL_PWR,
        ST_DEL_NRD,
        ST_DEL_NWR,
        ST_EMIT,
        ST_CLR_RD,
        ST_CLR_OUT
    } t_state;

    function automatic t_result make_result(
        t_status                status,
        logic [ID_W-1:0]        object_id,
        logic [SLOT_W-1:0]      slot,
        logic [MEMBERS_W-1:0]   members,
        logic                   last
    );
        t_result res;
        res.status    = status;
        res.object_id = object_id;
        res.slot      = slot;
        res.members   = members;
        res.last      = last;
        return res;
    endfunction

endpackage

[rtl/core/oss_mem.sv]
// Slot table memory: one write port, one read port with registered data.
// Depends on nothing; contents are undefined until written.
module oss_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/oss_outreg.sv]
// Output word register between the sequencer and the result stream.
// Depends on oss_pkg for the result type.
module oss_outreg
    import oss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/core/oss_ctrl.sv]
// Sequencer of the ordered selection set: scans the slot table, edits the links,
// walks the chain on clear. Depends on oss_pkg and the assertion macro header.
`include "ordered_selection_set_core_defines.svh"

module oss_ctrl
    import oss_pkg::*;
#(
    parameter int POOL_SLOTS = 32,
    parameter int ID_BITS    = 16,
    parameter int SW         = $clog2(POOL_SLOTS),
    parameter int MW         = 28
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_opcode         i_in_opcode,
    input  logic [ID_W-1:0] i_in_id,
    output logic            o_push,
    output t_result         o_res,
    input  logic            i_space,
    output logic            o_rd_en,
    output logic [SW-1:0]   o_rd_addr,
    input  logic [MW-1:0]   i_rd_data,
    output logic            o_wr_en,
    output logic [SW-1:0]   o_wr_addr,
    output logic [MW-1:0]   o_wr_data
);

    localparam int KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int LW    = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);

    // Table word: key in the top bits, then next link, then previous link.
    logic [KEY_W-1:0] rd_key;
    logic [LW-1:0]    rd_next;
    logic [LW-1:0]    rd_prev;

    assign rd_key  = i_rd_data[MW-1 -: KEY_W];
    assign rd_next = i_rd_data[2*LW-1:LW];
    assign rd_prev = i_rd_data[LW-1:0];

    t_state                r_state, n_state;
    logic [POOL_SLOTS-1:0] r_valid, n_valid;
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_tail, n_tail;
    logic [LW-1:0]         r_count, n_count;
    logic                  r_cmp_vld, n_cmp_vld;

    t_opcode               r_op, n_op;
    logic [KEY_W-1:0]      r_id, n_id;
    logic [LW-1:0]         r_idx, n_idx;
    logic [SW-1:0]         r_cmp_idx, n_cmp_idx;
    logic                  r_free_found, n_free_found;
    logic [SW-1:0]         r_free, n_free;
    logic [SW-1:0]         r_slot, n_slot;
    logic [LW-1:0]         r_prev, n_prev;
    logic [LW-1:0]         r_next, n_next;
    logic [LW-1:0]         r_cur, n_cur;
    logic [LW-1:0]         r_left, n_left;
    t_result               r_res, n_res;

    logic                  hit;
    logic                  clr_last;
    logic [LW-1:0]         left_dec;
    logic [LW-1:0]         count_dec;

    assign hit       = r_cmp_vld && r_valid[r_cmp_idx] && (rd_key == r_id);
    assign left_dec  = r_left - LW'(1);
    assign clr_last  = (left_dec == '0) || (rd_next >= NULL_LINK);
    assign count_dec = (r_count != '0) ? (r_count - LW'(1)) : r_count;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_cmp_vld    = r_cmp_vld;
        n_op         = r_op;
        n_id         = r_id;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_slot       = r_slot;
        n_prev       = r_prev;
        n_next       = r_next;
        n_cur        = r_cur;
        n_left       = r_left;
        n_res        = r_res;
        o_push       = 1'b0;
        o_res        = r_res;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = '0;
        o_wr_data    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_in_opcode;
                    n_id = i_in_id[KEY_W-1:0];
                    if (i_in_opcode == OP_CLEAR) begin
                        if ((r_count == '0) || (r_head >= NULL_LINK)) begin
                            n_res   = make_result(STAT_CLEAR_EMPTY, '0, '0, '0, 1'b1);
                            n_valid = '0;
                            n_head  = NULL_LINK;
                            n_tail  = NULL_LINK;
                            n_count = '0;
                            n_state = ST_EMIT;
                        end else begin
                            n_cur   = r_head;
                            n_left  = r_count;
                            n_state = ST_CLR_RD;
                        end
                    end else begin
                        n_idx        = '0;
                        n_cmp_vld    = 1'b0;
                        n_free_found = 1'b0;
                        n_state      = ST_SCAN;
                    end
                end
            end

            // One slot read is issued per cycle; its key is compared in the following cycle.
            ST_SCAN: begin
                if (hit) begin
                    n_slot    = r_cmp_idx;
                    n_next    = rd_next;
                    n_prev    = rd_prev;
                    n_cmp_vld = 1'b0;
                    if (r_op == OP_ADD) begin
                        n_res   = make_result(STAT_ALREADY, ID_W'(r_id), '0,
                                              MEMBERS_W'(r_count), 1'b1);
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_DEL;
                    end
                end else begin
                    if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = r_cmp_idx;
                    end
                    if (r_idx < NULL_LINK) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_idx[SW-1:0];
                        n_cmp_idx = r_idx[SW-1:0];
                        n_cmp_vld = 1'b1;
                        n_idx     = r_idx + LW'(1);
                    end else if (r_cmp_vld) begin
                        n_cmp_vld = 1'b0;
                    end else if (r_op == OP_DELETE) begin
                        n_res   = make_result(STAT_NOT_MEMBER, ID_W'(r_id), '0,
                                              MEMBERS_W'(r_count), 1'b1);
                        n_state = ST_EMIT;
                    end else if (r_free_found) begin
                        n_slot  = r_free;
                        n_state = ST_ADD;
                    end else begin
                        n_res   = make_result(STAT_FULL, ID_W'(r_id), '0,
                                              MEMBERS_W'(r_count), 1'b1);
                        n_state = ST_EMIT;
                    end
                end
            end

            ST_ADD: begin
                o_wr_en          = 1'b1;
                o_wr_addr        = r_slot;
                o_wr_data        = {r_id, NULL_LINK, r_tail};
                n_valid[r_slot]  = 1'b1;
                n_count          = r_count + LW'(1);
                n_tail           = LW'(r_slot);
                n_prev           = r_tail;
                n_res            = make_result(STAT_SELECTED, ID_W'(r_id), SLOT_W'(r_slot),
                                               MEMBERS_W'(r_count + LW'(1)), 1'b1);
                if (r_tail < NULL_LINK) begin
                    n_state = ST_ADD_TRD;
                end else begin
                    n_head  = LW'(r_slot);
                    n_state = ST_EMIT;
                end
            end

            ST_ADD_TRD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_prev[SW-1:0];
                n_state   = ST_ADD_TWR;
            end

            // The old tail keeps its key and back link and now points at the new slot.
            ST_ADD_TWR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_prev[SW-1:0];
                o_wr_data = {rd_key, LW'(r_slot), rd_prev};
                n_state   = ST_EMIT;
            end

            ST_DEL: begin
                n_valid[r_slot] = 1'b0;
                n_count         = count_dec;
                if (r_head == LW'(r_slot)) begin
                    n_head = r_next;
                end
                if (r_tail == LW'(r_slot)) begin
                    n_tail = r_prev;
                end
                n_res = make_result(STAT_UNSELECTED, ID_W'(r_id), SLOT_W'(r_slot),
                                    MEMBERS_W'(count_dec), 1'b1);
                if (r_prev < NULL_LINK) begin
                    n_state = ST_DEL_PRD;
                end else if (r_next < NULL_LINK) begin
                    n_state = ST_DEL_NRD;
                end else begin
                    n_state = ST_EMIT;
                end
            end

            ST_DEL_PRD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_prev[SW-1:0];
                n_state   = ST_DEL_PWR;
            end

            ST_DEL_PWR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_prev[SW-1:0];
                o_wr_data = {rd_key, r_next, rd_prev};
                n_state   = (r_next < NULL_LINK) ? ST_DEL_NRD : ST_EMIT;
            end

            ST_DEL_NRD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_next[SW-1:0];
                n_state   = ST_DEL_NWR;
            end

            ST_DEL_NWR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_next[SW-1:0];
                o_wr_data = {rd_key, rd_next, r_prev};
                n_state   = ST_EMIT;
            end

            ST_EMIT: begin
                if (i_space) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_CLR_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_cur[SW-1:0];
                n_state   = ST_CLR_OUT;
            end

            // The read data holds until the word is taken, so the walk can stall here.
            ST_CLR_OUT: begin
                o_res = make_result(STAT_CLEARED, ID_W'(rd_key), SLOT_W'(r_cur),
                                    MEMBERS_W'(left_dec), clr_last);
                if (i_space) begin
                    o_push = 1'b1;
                    n_left = left_dec;
                    if (clr_last) begin
                        n_valid = '0;
                        n_head  = NULL_LINK;
                        n_tail  = NULL_LINK;
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cur   = rd_next;
                        n_state = ST_CLR_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_head    <= NULL_LINK;
            r_tail    <= NULL_LINK;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_slot       <= n_slot;
        r_prev       <= n_prev;
        r_next       <= n_next;
        r_cur        <= n_cur;
        r_left       <= n_left;
        r_res        <= n_res;
    end

    `OSS_ASSERT_ALWAYS(a_count_matches_valid, $countones(r_valid) == int'(r_count), "member count differs from occupied slots")
    `OSS_ASSERT_ALWAYS(a_head_null_iff_empty, (r_count == '0) == (r_head == NULL_LINK), "head link disagrees with member count")
    `OSS_ASSERT_ALWAYS(a_tail_null_iff_head_null, (r_head == NULL_LINK) == (r_tail == NULL_LINK), "head and tail links disagree")
    `OSS_ASSERT_IMPLY(a_push_needs_space, o_push, i_space, "result pushed into a full output register")

endmodule

[rtl/core/ordered_selection_set_core.sv]
// Top level of the ordered selection set: stream ports, slot table, sequencer
// and output register. Depends on oss_pkg, oss_mem, oss_ctrl and oss_outreg.
//
// Keeps a set of up to POOL_SLOTS object ids in a slot table, chained in the
// order they were added. Each input word carries an opcode in tuser (add, delete,
// toggle, clear) and an id in tdata; ids are compared in their low ID_BITS bits.
// Add, delete and toggle each give one result word after a linear search of the
// table, which is read one slot per cycle through the single read port; the
// search ends early when the id is found. An add then writes the new slot and
// reads and rewrites the old tail link, and a delete reads and rewrites the links
// of its neighbors, the previous one first. The result is then handed to the
// output register before the next word is taken. Clear gives one word per
// member from oldest to newest, with tlast on the final one; a clear of an
// empty set gives a single word. The output register lets the next item be
// accepted while a result still waits. Occupancy bits are flip-flops cleared
// by reset, so no clearing pass follows reset.
module ordered_selection_set_core
    import oss_pkg::*;
#(
    parameter int POOL_SLOTS = 32,
    parameter int ID_BITS    = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [15:0] object_id
    input  logic [1:0]             i_s_axis_tuser,   // [1:0] opcode
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [15:0] object_id_out,
                                                     // [20:16] slot,
                                                     // [26:21] member_count, zeros above
    output logic [STATUS_W-1:0]    o_m_axis_tuser,   // [2:0] status
    output logic                   o_m_axis_tlast
);

    localparam int KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int LW    = $clog2(POOL_SLOTS + 1);
    localparam int SW    = $clog2(POOL_SLOTS);
    localparam int MW    = KEY_W + 2 * LW;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic [MW-1:0] rd_data;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic          push;
    logic          space;
    t_result       ctrl_res;
    t_result       out_res;

    oss_mem #(
        .DEPTH (POOL_SLOTS),
        .WIDTH (MW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    oss_ctrl #(
        .POOL_SLOTS (POOL_SLOTS),
        .ID_BITS    (ID_BITS),
        .SW         (SW),
        .MW         (MW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_opcode (t_opcode'(i_s_axis_tuser)),
        .i_in_id     (i_s_axis_tdata[ID_W-1:0]),
        .o_push      (push),
        .o_res       (ctrl_res),
        .i_space     (space),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    oss_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (ctrl_res),
        .o_space (space),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.members, out_res.slot,
                             out_res.object_id};
    assign o_m_axis_tuser = out_res.status;
    assign o_m_axis_tlast = out_res.last;

endmodule
